// ===== src/wcc_pkg.sv =====
// Shared constants, codes and types for the window co-occurrence counter.
// No dependencies; wcc_front, wcc_back and the top level import this package.
`default_nettype none

package wcc_pkg;

    localparam int DEF_VOCAB_SIZE = 64;
    localparam int DEF_MAX_RADIUS = 8;
    localparam int DEF_COUNT_BITS = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam int TOK_W      = 6;
    localparam int RAD_W      = 4;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int S_DATA_W   = 24;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 64;

    localparam logic [S_USER_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [S_USER_W-1:0] REQ_READ  = 2'd1;
    localparam logic [S_USER_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 1'd1;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_READ,
        CMD_CLEAR
    } cmd_op_t;

    localparam int CMD_OP_W = $bits(cmd_op_t);

    typedef enum logic [2:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_BUMP_RD,
        BK_BUMP_WR,
        BK_READ_RD,
        BK_READ_WR
    } bk_state_t;

    typedef struct packed {
        logic init_sweep;
    } bk_status_t;

endpackage

`default_nettype wire

// ===== src/wcc_queue.sv =====
// Small command queue between the front and back parts of the counter.
// No dependencies; it does not use wcc_pkg.
`default_nettype none

module wcc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             rd,
    output logic [WIDTH-1:0]      dout,
    output logic                  valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr && !rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign valid = (count_reg != '0);
    assign full  = (count_reg == CW'(DEPTH));

endmodule

`default_nettype wire

// ===== src/wcc_front.sv =====
// Front part: configuration registers, request classification and token history.
// Depends on wcc_pkg; feeds commands into wcc_queue.
`default_nettype none

module wcc_front #(
    parameter int VOCAB_SIZE = wcc_pkg::DEF_VOCAB_SIZE,
    parameter int MAX_RADIUS = wcc_pkg::DEF_MAX_RADIUS,
    localparam int RW = $clog2(VOCAB_SIZE),
    localparam int FW = $clog2(MAX_RADIUS + 1)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [wcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wcc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [wcc_pkg::S_DATA_W-1:0]    s_tdata,
    input  wire logic [wcc_pkg::S_USER_W-1:0]    s_tuser,
    input  wire logic                            q_full,
    input  wire wcc_pkg::bk_status_t             bk_status,
    output logic                                 q_wr,
    output wcc_pkg::cmd_op_t                     cmd_op,
    output logic [RW-1:0]                        cmd_a,
    output logic [RW-1:0]                        cmd_b,
    output logic                                 cmd_a_ok,
    output logic                                 cmd_b_ok,
    output logic                                 cmd_both,
    output logic [FW-1:0]                        cmd_n,
    output logic [MAX_RADIUS*RW-1:0]             cmd_partners
);

    import wcc_pkg::*;

    localparam int RCW = (FW > RAD_W) ? FW : RAD_W;

    logic                 mode_reg;
    logic [RAD_W-1:0]     radius_reg;
    logic [RW-1:0]        hist_reg [MAX_RADIUS];
    logic [FW-1:0]        fill_reg, fill_next;
    logic                 accept;
    logic                 push_ok;
    logic                 do_shift;
    logic [31:0]          tok_wide, row_wide, col_wide;
    logic [RCW-1:0]       rad_ext, rad_cl, fill_ext;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full && !bk_status.init_sweep;
    assign accept    = s_tvalid && s_tready;

    assign tok_wide = 32'(s_tdata[TOK_W-1:0]);
    assign row_wide = 32'(s_tdata[2*TOK_W-1:TOK_W]);
    assign col_wide = 32'(s_tdata[3*TOK_W-1:2*TOK_W]);

    assign rad_ext  = RCW'(radius_reg);
    assign rad_cl   = (rad_ext > RCW'(MAX_RADIUS)) ? RCW'(MAX_RADIUS) : rad_ext;
    assign fill_ext = RCW'(fill_reg);

    always_comb
    begin
        q_wr     = 1'b0;
        push_ok  = 1'b0;
        cmd_op   = CMD_PUSH;
        cmd_a    = tok_wide[RW-1:0];
        cmd_b    = col_wide[RW-1:0];
        cmd_a_ok = 1'b1;
        cmd_b_ok = 1'b1;
        cmd_both = !mode_reg;
        if (mode_reg)
        begin
            cmd_n = (fill_reg != '0) ? FW'(1) : '0;
        end
        else
        begin
            cmd_n = (rad_cl < fill_ext) ? FW'(rad_cl) : fill_reg;
        end
        unique case (s_tuser)
            REQ_PUSH:
            begin
                push_ok = (tok_wide < 32'(VOCAB_SIZE));
                q_wr    = accept && push_ok;
            end
            REQ_READ:
            begin
                cmd_op   = CMD_READ;
                cmd_a    = row_wide[RW-1:0];
                cmd_a_ok = (row_wide < 32'(VOCAB_SIZE));
                cmd_b_ok = (col_wide < 32'(VOCAB_SIZE));
                q_wr     = accept;
            end
            REQ_CLEAR:
            begin
                cmd_op = CMD_CLEAR;
                q_wr   = accept;
            end
            default:
            begin
                q_wr = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < MAX_RADIUS; k++)
        begin
            cmd_partners[k*RW +: RW] = hist_reg[k];
        end
    end

    assign do_shift = accept && (s_tuser == REQ_PUSH) && push_ok;

    always_comb
    begin
        fill_next = fill_reg;
        if (accept && (s_tuser == REQ_CLEAR))
        begin
            fill_next = '0;
        end
        else if (do_shift && (fill_reg != FW'(MAX_RADIUS)))
        begin
            fill_next = fill_reg + FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            radius_reg <= RAD_W'(1);
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_COUNT_MODE:    mode_reg   <= cfg_data[0];
                    CFG_WINDOW_RADIUS: radius_reg <= cfg_data;
                    default:           mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    // shift history, newest first
    always_ff @(posedge clk)
    begin
        if (do_shift)
        begin
            hist_reg[0] <= tok_wide[RW-1:0];
            for (int k = 1; k < MAX_RADIUS; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/wcc_back.sv =====
// Back part: pair table and row total memories, update sequencer and result register.
// Depends on wcc_pkg; takes commands from wcc_queue.
`default_nettype none

module wcc_back #(
    parameter int VOCAB_SIZE = wcc_pkg::DEF_VOCAB_SIZE,
    parameter int MAX_RADIUS = wcc_pkg::DEF_MAX_RADIUS,
    parameter int COUNT_BITS = wcc_pkg::DEF_COUNT_BITS,
    localparam int RW = $clog2(VOCAB_SIZE),
    localparam int FW = $clog2(MAX_RADIUS + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    output logic                               q_rd,
    input  wire wcc_pkg::cmd_op_t              q_op,
    input  wire logic [RW-1:0]                 q_a,
    input  wire logic [RW-1:0]                 q_b,
    input  wire logic                          q_a_ok,
    input  wire logic                          q_b_ok,
    input  wire logic                          q_both,
    input  wire logic [FW-1:0]                 q_n,
    input  wire logic [MAX_RADIUS*RW-1:0]      q_partners,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [wcc_pkg::M_DATA_W-1:0]       m_tdata,
    output wcc_pkg::bk_status_t                status
);

    import wcc_pkg::*;

    localparam int TW = 2 * RW;
    localparam int SW = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
    localparam int XW = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

    bk_state_t             state_reg, state_next;
    logic                  init_reg;
    logic [TW-1:0]         sweep_reg;
    logic [FW-1:0]         step_reg;
    logic                  dir_reg;
    logic [RW-1:0]         a_reg, b_reg;
    logic                  a_ok_reg, b_ok_reg, both_reg;
    logic [FW-1:0]         n_reg;
    logic [RW-1:0]         prt_reg [MAX_RADIUS];

    logic [COUNT_BITS-1:0] pair_mem [1 << TW];
    logic [COUNT_BITS-1:0] row_mem  [1 << RW];
    logic [COUNT_BITS-1:0] pair_rd_reg, row_rd_reg;

    logic                  out_valid_reg;
    logic [OUT_W-1:0]      pc_reg, rt_reg;

    logic [RW-1:0]         partner, row_sel, col_sel;
    logic [TW-1:0]         rd_addr, wr_addr;
    logic [RW-1:0]         row_wr_addr;
    logic                  pair_we, row_we;
    logic [COUNT_BITS-1:0] pair_wdata, row_wdata;
    logic                  cell_max, row_max;
    logic                  last_bump, sweep_done, out_free, out_load, dispatch;
    logic [XW-1:0]         pc_x, rt_x;
    logic [OUT_W-1:0]      pc_cl, rt_cl;

    assign partner    = prt_reg[step_reg[SW-1:0]];
    assign cell_max   = &pair_rd_reg;
    assign row_max    = &row_rd_reg;
    assign last_bump  = dir_reg && (step_reg == n_reg - FW'(1));
    assign sweep_done = (sweep_reg == '1);
    assign out_free   = !out_valid_reg || m_tready;
    assign dispatch   = (state_reg == BK_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_op)
                        CMD_CLEAR: state_next = BK_SWEEP;
                        CMD_READ:  state_next = BK_READ_RD;
                        CMD_PUSH:  state_next = (q_n == '0) ? BK_IDLE : BK_BUMP_RD;
                        default:   state_next = BK_IDLE;
                    endcase
                end
            end
            BK_BUMP_RD: state_next = BK_BUMP_WR;
            BK_BUMP_WR: state_next = last_bump ? BK_IDLE : BK_BUMP_RD;
            BK_READ_RD: state_next = BK_READ_WR;
            BK_READ_WR:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_rd        = dispatch;
        row_sel     = dir_reg ? partner : a_reg;
        col_sel     = dir_reg ? a_reg : partner;
        pair_we     = 1'b0;
        row_we      = 1'b0;
        pair_wdata  = pair_rd_reg + COUNT_BITS'(1);
        row_wdata   = row_rd_reg + COUNT_BITS'(1);
        out_load    = 1'b0;
        wr_addr     = {row_sel, col_sel};
        row_wr_addr = row_sel;
        unique case (state_reg)
            BK_SWEEP:
            begin
                pair_we     = 1'b1;
                row_we      = 1'b1;
                pair_wdata  = '0;
                row_wdata   = '0;
                wr_addr     = sweep_reg;
                row_wr_addr = sweep_reg[RW-1:0];
            end
            BK_BUMP_WR:
            begin
                pair_we = !cell_max;
                row_we  = !cell_max && !row_max;
            end
            BK_READ_RD, BK_READ_WR:
            begin
                row_sel  = a_reg;
                col_sel  = b_reg;
                out_load = (state_reg == BK_READ_WR) && out_free;
            end
            default:
            begin
                pair_we = 1'b0;
            end
        endcase
        rd_addr = {row_sel, col_sel};
    end

    always_ff @(posedge clk)
    begin
        if (pair_we)
        begin
            pair_mem[wr_addr] <= pair_wdata;
        end
        pair_rd_reg <= pair_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wr_addr] <= row_wdata;
        end
        row_rd_reg <= row_mem[row_sel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_SWEEP;
            init_reg      <= 1'b1;
            sweep_reg     <= '0;
            step_reg      <= '0;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_SWEEP)
            begin
                sweep_reg <= sweep_reg + TW'(1);
                if (sweep_done)
                begin
                    init_reg <= 1'b0;
                end
            end
            if (dispatch)
            begin
                sweep_reg <= '0;
                step_reg  <= '0;
                dir_reg   <= !q_both;
            end
            else if (state_reg == BK_BUMP_WR)
            begin
                // advance direction first, then the partner
                if (!dir_reg)
                begin
                    dir_reg <= 1'b1;
                end
                else
                begin
                    dir_reg  <= !both_reg;
                    step_reg <= step_reg + FW'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dispatch)
        begin
            a_reg    <= q_a;
            b_reg    <= q_b;
            a_ok_reg <= q_a_ok;
            b_ok_reg <= q_b_ok;
            both_reg <= q_both;
            n_reg    <= q_n;
            for (int k = 0; k < MAX_RADIUS; k++)
            begin
                prt_reg[k] <= q_partners[k*RW +: RW];
            end
        end
        if (out_load)
        begin
            pc_reg <= (a_ok_reg && b_ok_reg) ? pc_cl : '0;
            rt_reg <= a_ok_reg ? rt_cl : '0;
        end
    end

    assign pc_x  = XW'(pair_rd_reg);
    assign rt_x  = XW'(row_rd_reg);
    assign pc_cl = (pc_x > XW'({OUT_W{1'b1}})) ? '1 : pc_x[OUT_W-1:0];
    assign rt_cl = (rt_x > XW'({OUT_W{1'b1}})) ? '1 : rt_x[OUT_W-1:0];

    assign m_tvalid          = out_valid_reg;
    assign m_tdata           = {rt_reg, pc_reg};
    assign status.init_sweep = init_reg;

endmodule

`default_nettype wire

// ===== src/window_cooccurrence_counter.sv =====
// Top level of the window co-occurrence counter: front, command queue and back.
// Depends on wcc_pkg, wcc_front, wcc_queue and wcc_back.
//
//  channel   direction  handshake            payload
//  cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//  s_axis    in         s_tvalid/s_tready    s_tdata, s_tuser
//  m_axis    out        m_tvalid/m_tready    m_tdata
//
// A push passes the back through idle, then a table read and a table write per update:
// two updates per window partner in co-occurrence mode, one in transition mode. A read
// passes through idle, a table read and a result write. Reset and every clear run a zeroing
// pass over the pair table, one entry a cycle; s_tready is low during the reset pass.
// The queue holds two transactions, so the front keeps accepting while the back works.
// A result waiting on m_tready stalls the back only at its next read.
`default_nettype none

module window_cooccurrence_counter #(
    parameter int VOCAB_SIZE = wcc_pkg::DEF_VOCAB_SIZE,
    parameter int MAX_RADIUS = wcc_pkg::DEF_MAX_RADIUS,
    parameter int COUNT_BITS = wcc_pkg::DEF_COUNT_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [wcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wcc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // token[5:0], row_index[11:6], col_index[17:12], zero[23:18]
    input  wire logic [wcc_pkg::S_DATA_W-1:0]    s_tdata,
    // req_type[1:0]
    input  wire logic [wcc_pkg::S_USER_W-1:0]    s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // pair_count[31:0], row_total[63:32]
    output logic [wcc_pkg::M_DATA_W-1:0]         m_tdata
);

    import wcc_pkg::*;

    localparam int RW = $clog2(VOCAB_SIZE);
    localparam int FW = $clog2(MAX_RADIUS + 1);
    localparam int QW = CMD_OP_W + 2 * RW + 3 + FW + MAX_RADIUS * RW;

    logic                     q_wr, q_rd, q_full, q_valid;
    logic [QW-1:0]            q_din, q_dout;
    bk_status_t               bk_status;

    cmd_op_t                  f_op;
    logic [RW-1:0]            f_a, f_b;
    logic                     f_a_ok, f_b_ok, f_both;
    logic [FW-1:0]            f_n;
    logic [MAX_RADIUS*RW-1:0] f_partners;

    cmd_op_t                  b_op;
    logic [RW-1:0]            b_a, b_b;
    logic                     b_a_ok, b_b_ok, b_both;
    logic [FW-1:0]            b_n;
    logic [MAX_RADIUS*RW-1:0] b_partners;

    wcc_front #(
        .VOCAB_SIZE (VOCAB_SIZE),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .q_full       (q_full),
        .bk_status    (bk_status),
        .q_wr         (q_wr),
        .cmd_op       (f_op),
        .cmd_a        (f_a),
        .cmd_b        (f_b),
        .cmd_a_ok     (f_a_ok),
        .cmd_b_ok     (f_b_ok),
        .cmd_both     (f_both),
        .cmd_n        (f_n),
        .cmd_partners (f_partners)
    );

    assign q_din = {f_op, f_a, f_b, f_a_ok, f_b_ok, f_both, f_n, f_partners};

    wcc_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .din   (q_din),
        .full  (q_full),
        .rd    (q_rd),
        .dout  (q_dout),
        .valid (q_valid)
    );

    assign b_op       = cmd_op_t'(q_dout[QW-1 -: CMD_OP_W]);
    assign b_a        = q_dout[QW-CMD_OP_W-1 -: RW];
    assign b_b        = q_dout[QW-CMD_OP_W-RW-1 -: RW];
    assign b_a_ok     = q_dout[FW + MAX_RADIUS*RW + 2];
    assign b_b_ok     = q_dout[FW + MAX_RADIUS*RW + 1];
    assign b_both     = q_dout[FW + MAX_RADIUS*RW];
    assign b_n        = q_dout[MAX_RADIUS*RW +: FW];
    assign b_partners = q_dout[MAX_RADIUS*RW-1:0];

    wcc_back #(
        .VOCAB_SIZE (VOCAB_SIZE),
        .MAX_RADIUS (MAX_RADIUS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_rd       (q_rd),
        .q_op       (b_op),
        .q_a        (b_a),
        .q_b        (b_b),
        .q_a_ok     (b_a_ok),
        .q_b_ok     (b_b_ok),
        .q_both     (b_both),
        .q_n        (b_n),
        .q_partners (b_partners),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .status     (bk_status)
    );

    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_wr && q_full))
        else $error("command queue written while full");

    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.init_sweep |-> !(s_tvalid && s_tready))
        else $error("transaction accepted during reset zeroing pass");

    a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.init_sweep |-> !m_tvalid)
        else $error("result presented during reset zeroing pass");

endmodule

`default_nettype wire

// ===== tb/window_cooccurrence_counter_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for window_cooccurrence_counter: a directed table, then random
// request phases under several register settings and idle patterns, each read checked.
// Depends on wcc_pkg and the window_cooccurrence_counter RTL.

module window_cooccurrence_counter_tb;

    import wcc_pkg::*;

    localparam logic [S_USER_W-1:0] REQ_UNUSED = 2'd3;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 170;
    // two queued pushes at the widest window, plus margin
    localparam int SETTLE_CYCLES = 2 * (1 + 4 * DEF_MAX_RADIUS) + 10;
    localparam int TAIL_CYCLES   = 100;

    typedef struct packed {
        logic [OUT_W-1:0] row_total;
        logic [OUT_W-1:0] pair_count;
    } read_result_t;

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [S_USER_W-1:0]   req;
        logic [TOK_W-1:0]      tok;
        logic [TOK_W-1:0]      row;
        logic [TOK_W-1:0]      col;
        bit                    typed;
        logic [OUT_W-1:0]      pc;
        logic [OUT_W-1:0]      rt;
    } dir_step_t;

    localparam dir_step_t DIRECTED [26] = '{
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd0, 6'd0, 6'd0, 1'b1, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd63, 6'd63, 6'd63, 1'b1, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_PUSH, 6'd5, 6'd63, 6'd0, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd0, 6'd5, 6'd5, 1'b1, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_PUSH, 6'd5, 6'd0, 6'd63, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd0, 6'd5, 6'd5, 1'b1, 32'd2, 32'd2},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_PUSH, 6'd63, 6'd0, 6'd0, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd0, 6'd5, 6'd63, 1'b1, 32'd1, 32'd3},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_UNUSED, 6'd63, 6'd63, 6'd63, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd0, 6'd63, 6'd5, 1'b1, 32'd1, 32'd1},
        '{1'b1, CFG_WINDOW_RADIUS, 4'd0, REQ_PUSH, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_PUSH, 6'd0, 6'd63, 6'd63, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd0, 6'd0, 6'd63, 1'b1, 32'd0, 32'd0},
        '{1'b1, CFG_WINDOW_RADIUS, 4'd15, REQ_PUSH, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_PUSH, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd0, 6'd0, 6'd5, 1'b1, 32'd2, 32'd5},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd0, 6'd5, 6'd0, 1'b0, 32'd0, 32'd0},
        '{1'b1, CFG_COUNT_MODE, 4'd1, REQ_PUSH, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_PUSH, 6'd63, 6'd0, 6'd0, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd0, 6'd0, 6'd63, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_CLEAR, 6'd63, 6'd63, 6'd63, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd0, 6'd5, 6'd5, 1'b1, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_PUSH, 6'd1, 6'd0, 6'd0, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_PUSH, 6'd2, 6'd0, 6'd0, 1'b0, 32'd0, 32'd0},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd0, 6'd1, 6'd2, 1'b1, 32'd1, 32'd1},
        '{1'b0, CFG_COUNT_MODE, 4'd0, REQ_READ, 6'd0, 6'd63, 6'd0, 1'b0, 32'd0, 32'd0}
    };

    localparam bit       PHASE_MODE   [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam bit [3:0] PHASE_RADIUS [NUM_PHASES] = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd8, 4'd5};
    localparam int       PHASE_SEND_IDLE [NUM_PHASES] = '{7, 7, 69, 69, 0, 0};
    localparam int       PHASE_RECV_IDLE [NUM_PHASES] = '{69, 69, 7, 7, 0, 0};

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [S_USER_W-1:0]   s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    bit [OUT_W-1:0] pair_cnt [DEF_VOCAB_SIZE][DEF_VOCAB_SIZE];
    bit [OUT_W-1:0] row_sum  [DEF_VOCAB_SIZE];
    bit [TOK_W-1:0] recent_tok [DEF_MAX_RADIUS];
    int             recent_fill;
    bit             cur_mode;
    bit [RAD_W-1:0] cur_radius;

    read_result_t cell_reads_due [$];

    int errors;
    int items_sent;
    int reads_checked;
    int clears_sent;
    int cfg_writes;
    int send_idle_pct;
    int recv_idle_pct;

    window_cooccurrence_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("== FAIL ==");
        $finish;
    end

    function automatic void count_pair(input logic [TOK_W-1:0] r, input logic [TOK_W-1:0] c);
        if (pair_cnt[r][c] != {OUT_W{1'b1}})
        begin
            pair_cnt[r][c]++;
            if (row_sum[r] != {OUT_W{1'b1}})
                row_sum[r]++;
        end
    endfunction

    function automatic void clear_counts();
        foreach (pair_cnt[r, c])
            pair_cnt[r][c] = '0;
        foreach (row_sum[r])
            row_sum[r] = '0;
        foreach (recent_tok[k])
            recent_tok[k] = '0;
        recent_fill = 0;
    endfunction

    function automatic bit apply_request(input logic [S_USER_W-1:0] req,
                                         input logic [TOK_W-1:0] tok,
                                         input logic [TOK_W-1:0] row,
                                         input logic [TOK_W-1:0] col,
                                         output read_result_t res);
        int lim;
        int n;
        res = '0;
        case (req)
            REQ_PUSH:
            begin
                if (cur_mode == 1'b0)
                begin
                    lim = (cur_radius > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : int'(cur_radius);
                    n = (lim < recent_fill) ? lim : recent_fill;
                    for (int k = 0; k < n; k++)
                    begin
                        count_pair(tok, recent_tok[k]);
                        count_pair(recent_tok[k], tok);
                    end
                end
                else if (recent_fill > 0)
                begin
                    count_pair(recent_tok[0], tok);
                end
                for (int k = DEF_MAX_RADIUS - 1; k > 0; k--)
                    recent_tok[k] = recent_tok[k-1];
                recent_tok[0] = tok;
                if (recent_fill < DEF_MAX_RADIUS)
                    recent_fill++;
                return 1'b0;
            end
            REQ_READ:
            begin
                res.pair_count = pair_cnt[row][col];
                res.row_total  = row_sum[row];
                return 1'b1;
            end
            REQ_CLEAR:
            begin
                clear_counts();
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic send_request(input logic [S_USER_W-1:0] req,
                                input logic [TOK_W-1:0] tok,
                                input logic [TOK_W-1:0] row,
                                input logic [TOK_W-1:0] col,
                                input bit typed,
                                input logic [OUT_W-1:0] typed_pc,
                                input logic [OUT_W-1:0] typed_rt);
        read_result_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - 3*TOK_W){1'b0}}, col, row, tok};
        s_tuser  <= req;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (req == REQ_CLEAR)
            clears_sent++;
        if (apply_request(req, tok, row, col, res))
        begin
            if (typed)
                res = '{row_total: typed_rt, pair_count: typed_pc};
            cell_reads_due.insert(cell_reads_due.size(), res);
        end
    endtask

    // hold the request stream until every read has returned and the back end is quiet
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (cell_reads_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_COUNT_MODE)
            cur_mode = val[0];
        else
            cur_radius = val[RAD_W-1:0];
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        read_result_t got;
        read_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (cell_reads_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = cell_reads_due.pop_front();
                reads_checked++;
                if (got.pair_count !== want.pair_count)
                begin
                    errors++;
                    $display("%0t: pair_count mismatch, expected %0d, actual %0d",
                             $time, want.pair_count, got.pair_count);
                end
                if (got.row_total !== want.row_total)
                begin
                    errors++;
                    $display("%0t: row_total mismatch, expected %0d, actual %0d",
                             $time, want.row_total, got.row_total);
                end
            end
        end
    end

    initial
    begin
        logic [S_USER_W-1:0] req;
        logic [TOK_W-1:0]    tok;
        logic [TOK_W-1:0]    row;
        logic [TOK_W-1:0]    col;
        logic [TOK_W-1:0]    hot_base;
        int                  pick;
        int                  waited;

        errors        = 0;
        items_sent    = 0;
        reads_checked = 0;
        clears_sent   = 0;
        cfg_writes    = 0;
        cur_mode      = 1'b0;
        cur_radius    = 4'd1;
        clear_counts();
        send_idle_pct = PHASE_SEND_IDLE[0];
        recv_idle_pct = PHASE_RECV_IDLE[0];

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].is_cfg)
            begin
                settle();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
            end
            else
            begin
                send_request(DIRECTED[i].req, DIRECTED[i].tok, DIRECTED[i].row,
                             DIRECTED[i].col, DIRECTED[i].typed, DIRECTED[i].pc,
                             DIRECTED[i].rt);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            write_reg(CFG_COUNT_MODE, {{(CFG_DATA_W-1){1'b0}}, PHASE_MODE[ph]});
            write_reg(CFG_WINDOW_RADIUS, PHASE_RADIUS[ph]);
            send_idle_pct = PHASE_SEND_IDLE[ph];
            recv_idle_pct = PHASE_RECV_IDLE[ph];
            hot_base = TOK_W'($urandom_range(DEF_VOCAB_SIZE - 8));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(999);
                // bias tokens and reads toward a small cluster so counts build up
                tok = $urandom_range(1) ? TOK_W'(hot_base + $urandom_range(7))
                                        : TOK_W'($urandom_range(63));
                row = ($urandom_range(9) < 7) ? TOK_W'(hot_base + $urandom_range(7))
                                              : TOK_W'($urandom_range(63));
                col = ($urandom_range(9) < 7) ? TOK_W'(hot_base + $urandom_range(7))
                                              : TOK_W'($urandom_range(63));
                if (pick < 8)
                    req = REQ_CLEAR;
                else if (pick < 40)
                    req = REQ_UNUSED;
                else if (pick < 330)
                    req = REQ_READ;
                else
                    req = REQ_PUSH;
                send_request(req, tok, row, col, 1'b0, '0, '0);
                if (i == PHASE_ITEMS / 2)
                    settle();
            end
            send_request(REQ_READ, TOK_W'($urandom_range(63)),
                         TOK_W'(hot_base + $urandom_range(7)),
                         TOK_W'(hot_base + $urandom_range(7)), 1'b0, '0, '0);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (cell_reads_due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (cell_reads_due.size() != 0)
        begin
            errors += cell_reads_due.size();
            $display("%0t: %0d reads never returned", $time, cell_reads_due.size());
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d clears) over %0d register writes in both count modes,",
                 items_sent, clears_sent, cfg_writes);
        $display("radius 0 to 15 and three idle patterns; %0d cell reads compared, %0d errors.",
                 reads_checked, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
